FILE: src/tcce_pkg.sv
// shared types and constants of the text console cell engine
// used by tcce_ctrl, text_console_cell_engine_unit and the testbench; depends on nothing

package tcce_pkg;

  // store geometry
  localparam int MAX_COLUMNS = 80;
  localparam int MAX_ROWS    = 25;
  localparam int STORE_CELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W      = $clog2(STORE_CELLS);
  localparam int CELL_W      = 16;

  // field widths fixed by the interface
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int ATTR_W  = 8;
  localparam int PITCH_W = 11;
  localparam int CFG_W   = 11;
  localparam int OFS_W   = 16;

  // request codes
  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_LINE_LENGTH = 2'd0;
  localparam logic [1:0] REG_ROW_COUNT   = 2'd1;
  localparam logic [1:0] REG_TEXT_ATTR   = 2'd2;
  localparam logic [1:0] REG_DISP_PITCH  = 2'd3;

  // control characters
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_SPACE = 8'd32;

  // register reset values
  localparam logic [COL_W-1:0]   LINE_LENGTH_RST = COL_W'(MAX_COLUMNS);
  localparam logic [ROW_W-1:0]   ROW_COUNT_RST   = ROW_W'(MAX_ROWS);
  localparam logic [ATTR_W-1:0]  TEXT_ATTR_RST   = 8'h0F;
  localparam logic [PITCH_W-1:0] DISP_PITCH_RST  = PITCH_W'(MAX_COLUMNS);
  localparam logic [CELL_W-1:0]  RESET_CELL      = {TEXT_ATTR_RST, CH_SPACE};

  // effective geometry after clamping
  typedef struct packed {
    logic [COL_W-1:0]   cols;
    logic [ROW_W-1:0]   rows;
    logic [ATTR_W-1:0]  attr;
    logic [PITCH_W-1:0] pitch;
  } geom_t;

  // store access from the sequencer
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // one result item
  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [ADDR_W-1:0] cursor_position;
    logic              cell_written;
    logic [ADDR_W-1:0] cell_address;
    logic [CELL_W-1:0] cell_value;
    logic [OFS_W-1:0]  display_offset;
    logic              redraw_needed;
  } result_t;

endpackage

FILE: src/tcce_ram.sv
// generic single-write, single-read synchronous ram with registered read
// depends on nothing

module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/tcce_ctrl.sv
// request sequencer: cursor, cell writes, scroll copy, clear and init sweeps
// depends on tcce_pkg; drives the cell store through a mem_req_t

module tcce_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tcce_pkg::geom_t                geom,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_req_type,
  input  logic [7:0]                     in_char_code,
  input  logic [tcce_pkg::ADDR_W-1:0]    in_cell_index,
  output tcce_pkg::mem_req_t             mem_req,
  input  logic [tcce_pkg::CELL_W-1:0]    mem_rdata,
  output logic                           res_valid,
  input  logic                           res_ready,
  output tcce_pkg::result_t              res
);
  import tcce_pkg::*;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_EXEC, S_RDATA, S_COPY, S_FILL, S_CLEAR, S_DONE
  } state_t;

  state_t              state_r;
  logic [ROW_W-1:0]    row_r;
  logic [COL_W-1:0]    col_r;
  logic [1:0]          req_r;
  logic [7:0]          ch_r;
  logic [ADDR_W-1:0]   idx_r;
  logic [ADDR_W-1:0]   cnt_r;
  logic                pend_r;
  logic [ADDR_W-1:0]   pend_addr_r;
  logic [ADDR_W-1:0]   moved_r;
  logic                written_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [CELL_W-1:0]   value_r;
  logic [OFS_W-1:0]    offset_r;
  logic                redraw_r;

  logic [ADDR_W:0]     row_x_cols;
  logic [ADDR_W:0]     cell_lin;
  logic [OFS_W:0]      disp_lin;
  logic [ADDR_W:0]     moved_lin;
  logic [ROW_W-1:0]    row_clamp;
  logic [COL_W-1:0]    col_clamp;
  logic                last_row;
  logic                line_end;
  logic                cnt_last;
  logic                fill_last;
  logic [CELL_W-1:0]   blank_cell;
  logic [CELL_W-1:0]   put_cell;
  logic                is_ctrl_char;

  // cursor arithmetic, one multiplier per product
  always_comb begin
    row_x_cols   = (ADDR_W + 1)'(row_r) * (ADDR_W + 1)'(geom.cols);
    cell_lin     = row_x_cols + (ADDR_W + 1)'(col_r);
    disp_lin     = (OFS_W + 1)'(row_r) * (OFS_W + 1)'(geom.pitch) + (OFS_W + 1)'(col_r);
    moved_lin    = (ADDR_W + 1)'(geom.rows - ROW_W'(1)) * (ADDR_W + 1)'(geom.cols);
    row_clamp    = (row_r >= geom.rows) ? geom.rows - ROW_W'(1) : row_r;
    col_clamp    = (col_r >= geom.cols) ? geom.cols - COL_W'(1) : col_r;
    last_row     = ((ROW_W + 1)'(row_r) + (ROW_W + 1)'(1)) >= (ROW_W + 1)'(geom.rows);
    line_end     = ((COL_W + 1)'(col_r) + (COL_W + 1)'(1)) >= (COL_W + 1)'(geom.cols);
    cnt_last     = (cnt_r == ADDR_W'(STORE_CELLS - 1));
    fill_last    = ((ADDR_W + 1)'(cnt_r) + (ADDR_W + 1)'(1)) ==
                   ((ADDR_W + 1)'(moved_r) + (ADDR_W + 1)'(geom.cols));
    blank_cell   = {geom.attr, CH_SPACE};
    put_cell     = {geom.attr, ch_r};
    is_ctrl_char = (ch_r == CH_LF) || (ch_r == CH_CR) || (ch_r == CH_BS);
  end

  // store access per state
  always_comb begin
    mem_req = '0;
    case (state_r)
      S_INIT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cnt_r;
        mem_req.wdata = RESET_CELL;
      end
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cnt_r;
        mem_req.wdata = blank_cell;
      end
      S_EXEC: begin
        if (req_r == REQ_PUT && !is_ctrl_char) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = cell_lin[ADDR_W-1:0];
          mem_req.wdata = put_cell;
        end
        if (req_r == REQ_READ && idx_r < ADDR_W'(STORE_CELLS)) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_r;
        end
      end
      S_COPY: begin
        // read one row ahead, write back the word read last cycle
        if (cnt_r < moved_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = cnt_r + ADDR_W'(geom.cols);
        end
        if (pend_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pend_addr_r;
          mem_req.wdata = mem_rdata;
        end
      end
      S_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cnt_r;
        mem_req.wdata = blank_cell;
      end
      default: ;
    endcase
  end

  // handshakes and result
  always_comb begin
    in_ready            = (state_r == S_IDLE);
    res_valid           = (state_r == S_DONE);
    res.cursor_row      = row_r;
    res.cursor_col      = col_r;
    res.cursor_position = cell_lin[ADDR_W-1:0];
    res.cell_written    = written_r;
    res.cell_address    = addr_r;
    res.cell_value      = value_r;
    res.display_offset  = offset_r;
    res.redraw_needed   = redraw_r;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cnt_r   <= '0;
      row_r   <= '0;
      col_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_INIT: begin
          cnt_r <= cnt_last ? '0 : cnt_r + ADDR_W'(1);
          if (cnt_last) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req_r     <= in_req_type;
            ch_r      <= in_char_code;
            idx_r     <= in_cell_index;
            row_r     <= row_clamp;
            col_r     <= col_clamp;
            written_r <= 1'b0;
            addr_r    <= '0;
            value_r   <= '0;
            offset_r  <= '0;
            redraw_r  <= 1'b0;
            state_r   <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= S_DONE;
          case (req_r)
            REQ_PUT: begin
              if (ch_r == CH_CR) begin
                col_r <= '0;
              end else if (ch_r == CH_BS) begin
                if (col_r != '0) begin
                  col_r <= col_r - COL_W'(1);
                end
              end else begin
                if (ch_r != CH_LF) begin
                  written_r <= 1'b1;
                  addr_r    <= cell_lin[ADDR_W-1:0];
                  value_r   <= put_cell;
                  offset_r  <= disp_lin[OFS_W-1:0];
                end
                if (ch_r == CH_LF || line_end) begin
                  // new line, scrolling past the last row
                  col_r <= '0;
                  if (last_row) begin
                    redraw_r <= 1'b1;
                    cnt_r    <= '0;
                    pend_r   <= 1'b0;
                    moved_r  <= moved_lin[ADDR_W-1:0];
                    state_r  <= S_COPY;
                  end else begin
                    row_r <= row_r + ROW_W'(1);
                  end
                end else begin
                  col_r <= col_r + COL_W'(1);
                end
              end
            end
            REQ_CLEAR: begin
              row_r    <= '0;
              col_r    <= '0;
              redraw_r <= 1'b1;
              cnt_r    <= '0;
              state_r  <= S_CLEAR;
            end
            REQ_READ: begin
              addr_r <= idx_r;
              if (idx_r < ADDR_W'(STORE_CELLS)) begin
                state_r <= S_RDATA;
              end
            end
            default: ;
          endcase
        end
        S_RDATA: begin
          value_r <= mem_rdata;
          state_r <= S_DONE;
        end
        S_COPY: begin
          if (cnt_r < moved_r) begin
            pend_r      <= 1'b1;
            pend_addr_r <= cnt_r;
            cnt_r       <= cnt_r + ADDR_W'(1);
          end else begin
            pend_r <= 1'b0;
            if (!pend_r) begin
              state_r <= S_FILL;
            end
          end
        end
        S_FILL: begin
          cnt_r <= cnt_r + ADDR_W'(1);
          if (fill_last) begin
            state_r <= S_DONE;
          end
        end
        S_CLEAR: begin
          cnt_r <= cnt_last ? '0 : cnt_r + ADDR_W'(1);
          if (cnt_last) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/text_console_cell_engine_unit.sv
// top level of the text console cell engine: config registers, cell store,
// sequencer and output register; depends on tcce_pkg, tcce_ram, tcce_ctrl
//
// requests are taken one at a time: in_ready stays low from a transfer until its
// result has been passed to the output register; a put that scrolls copies the
// rows up and blanks the last row, a clear blanks the whole store first
// reset: synchronous active low; a sweep over all 2000 cells then blanks the store
// before in_ready rises, config writes are taken during it

module text_console_cell_engine_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [tcce_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_req_type,
  input  logic [7:0]                      in_char_code,
  input  logic [tcce_pkg::ADDR_W-1:0]     in_cell_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tcce_pkg::ROW_W-1:0]      out_cursor_row,
  output logic [tcce_pkg::COL_W-1:0]      out_cursor_col,
  output logic [tcce_pkg::ADDR_W-1:0]     out_cursor_position,
  output logic                            out_cell_written,
  output logic [tcce_pkg::ADDR_W-1:0]     out_cell_address,
  output logic [tcce_pkg::CELL_W-1:0]     out_cell_value,
  output logic [tcce_pkg::OFS_W-1:0]      out_display_offset,
  output logic                            out_redraw_needed
);
  import tcce_pkg::*;

  logic [COL_W-1:0]   line_length_r;
  logic [ROW_W-1:0]   row_count_r;
  logic [ATTR_W-1:0]  text_attr_r;
  logic [PITCH_W-1:0] disp_pitch_r;
  geom_t              geom;
  mem_req_t           mem_req;
  logic [CELL_W-1:0]  mem_rdata;
  logic               res_valid;
  logic               res_ready;
  result_t            res;
  logic               out_valid_r;
  result_t            out_r;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r <= LINE_LENGTH_RST;
      row_count_r   <= ROW_COUNT_RST;
      text_attr_r   <= TEXT_ATTR_RST;
      disp_pitch_r  <= DISP_PITCH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LINE_LENGTH: line_length_r <= cfg_data[COL_W-1:0];
        REG_ROW_COUNT:   row_count_r   <= cfg_data[ROW_W-1:0];
        REG_TEXT_ATTR:   text_attr_r   <= cfg_data[ATTR_W-1:0];
        REG_DISP_PITCH:  disp_pitch_r  <= cfg_data[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped geometry, zero pitch follows the line length
  always_comb begin
    if (line_length_r == '0) begin
      geom.cols = COL_W'(1);
    end else if (line_length_r > COL_W'(MAX_COLUMNS)) begin
      geom.cols = COL_W'(MAX_COLUMNS);
    end else begin
      geom.cols = line_length_r;
    end
    if (row_count_r == '0) begin
      geom.rows = ROW_W'(1);
    end else if (row_count_r > ROW_W'(MAX_ROWS)) begin
      geom.rows = ROW_W'(MAX_ROWS);
    end else begin
      geom.rows = row_count_r;
    end
    geom.attr  = text_attr_r;
    geom.pitch = (disp_pitch_r == '0) ? PITCH_W'(geom.cols) : disp_pitch_r;
  end

  // cell store
  tcce_ram #(
    .WIDTH (CELL_W),
    .DEPTH (STORE_CELLS)
  ) u_store (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // request sequencer
  tcce_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .geom          (geom),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_char_code  (in_char_code),
    .in_cell_index (in_cell_index),
    .mem_req       (mem_req),
    .mem_rdata     (mem_rdata),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  // output register
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cursor_row      = out_r.cursor_row;
  assign out_cursor_col      = out_r.cursor_col;
  assign out_cursor_position = out_r.cursor_position;
  assign out_cell_written    = out_r.cell_written;
  assign out_cell_address    = out_r.cell_address;
  assign out_cell_value      = out_r.cell_value;
  assign out_display_offset  = out_r.display_offset;
  assign out_redraw_needed   = out_r.redraw_needed;

endmodule

FILE: src/tcce_checker.sv
// port-level checks of the text console cell engine and their bind
// depends on text_console_cell_engine_unit

module tcce_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index,
  input logic [10:0] cfg_data,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_req_type,
  input logic [7:0]  in_char_code,
  input logic [10:0] in_cell_index,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  out_cursor_row,
  input logic [6:0]  out_cursor_col,
  input logic [10:0] out_cursor_position,
  input logic        out_cell_written,
  input logic [10:0] out_cell_address,
  input logic [15:0] out_cell_value,
  input logic [15:0] out_display_offset,
  input logic        out_redraw_needed
);

  // a stalled result stays valid with its cell value and cursor position
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cell_value) &&
      $stable(out_cursor_position))
    else $error("result changed while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one request at a time: busy after every transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // cursor stays inside the largest screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cursor_row < 5'd25 && out_cursor_col < 7'd80)
    else $error("cursor outside the screen");

  // display offset only accompanies a written cell
  a_offset_written: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_cell_written |-> out_display_offset == 16'd0)
    else $error("display offset without a cell write");

endmodule

bind text_console_cell_engine_unit tcce_checker u_tcce_checker (.*);

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for text_console_cell_engine_unit: directed and random requests
// checked against a cell store and cursor predictor kept here; depends on tcce_pkg and src rtl

module testbench;
  import tcce_pkg::*;

  // request code with no meaning, must change nothing
  localparam logic [1:0] REQ_NONE = 2'd3;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 2500;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 73;

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_req_type;
  logic [7:0]         in_char_code;
  logic [ADDR_W-1:0]  in_cell_index;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [ROW_W-1:0]   out_cursor_row;
  logic [COL_W-1:0]   out_cursor_col;
  logic [ADDR_W-1:0]  out_cursor_position;
  logic               out_cell_written;
  logic [ADDR_W-1:0]  out_cell_address;
  logic [CELL_W-1:0]  out_cell_value;
  logic [OFS_W-1:0]   out_display_offset;
  logic               out_redraw_needed;

  text_console_cell_engine_unit uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_char_code        (in_char_code),
    .in_cell_index       (in_cell_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_cursor_row      (out_cursor_row),
    .out_cursor_col      (out_cursor_col),
    .out_cursor_position (out_cursor_position),
    .out_cell_written    (out_cell_written),
    .out_cell_address    (out_cell_address),
    .out_cell_value      (out_cell_value),
    .out_display_offset  (out_display_offset),
    .out_redraw_needed   (out_redraw_needed)
  );

  // predicted console state
  logic [CELL_W-1:0]  shadow_cells [STORE_CELLS];
  int unsigned        crs_row;
  int unsigned        crs_col;
  logic [COL_W-1:0]   line_len_reg;
  logic [ROW_W-1:0]   row_cnt_reg;
  logic [ATTR_W-1:0]  attr_reg;
  logic [PITCH_W-1:0] pitch_reg;

  result_t awaited_reports[$];
  int      mismatches  = 0;
  int      burst_left  = 0;
  bit      steady_in   = 1'b0;
  bit      steady_out  = 1'b0;
  int      rx_stall    = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // clamped geometry
  function automatic int unsigned eff_cols();
    if (line_len_reg == 0) return 1;
    if (line_len_reg > MAX_COLUMNS) return MAX_COLUMNS;
    return 32'(line_len_reg);
  endfunction

  function automatic int unsigned eff_rows();
    if (row_cnt_reg == 0) return 1;
    if (row_cnt_reg > MAX_ROWS) return MAX_ROWS;
    return 32'(row_cnt_reg);
  endfunction

  task automatic console_reset();
    line_len_reg = LINE_LENGTH_RST;
    row_cnt_reg  = ROW_COUNT_RST;
    attr_reg     = TEXT_ATTR_RST;
    pitch_reg    = DISP_PITCH_RST;
    crs_row      = 0;
    crs_col      = 0;
    for (int i = 0; i < STORE_CELLS; i++) shadow_cells[i] = RESET_CELL;
  endtask

  // move to the next row, scrolling up one line past the last row
  task automatic console_newline(input int unsigned cols, input int unsigned rows,
                                 inout logic redraw);
    crs_row++;
    if (crs_row >= rows) begin
      for (int i = 0; i < (rows - 1) * cols; i++) shadow_cells[i] = shadow_cells[i + cols];
      for (int i = 0; i < cols; i++) shadow_cells[(rows - 1) * cols + i] = {attr_reg, CH_SPACE};
      crs_row = rows - 1;
      redraw  = 1'b1;
    end
  endtask

  // apply one request to the predicted state and build its report
  task automatic console_apply(input logic [1:0] req, input logic [7:0] ch,
                               input logic [ADDR_W-1:0] idx, output result_t res);
    int unsigned cols;
    int unsigned rows;
    int unsigned pitch;
    int unsigned addr;
    logic        redraw;
    cols   = eff_cols();
    rows   = eff_rows();
    pitch  = (pitch_reg == 0) ? cols : 32'(pitch_reg);
    redraw = 1'b0;
    res    = '0;
    // cursor left outside by a geometry change
    if (crs_row >= rows) crs_row = rows - 1;
    if (crs_col >= cols) crs_col = cols - 1;
    case (req)
      REQ_PUT: begin
        if (ch == CH_LF) begin
          crs_col = 0;
          console_newline(cols, rows, redraw);
        end else if (ch == CH_CR) begin
          crs_col = 0;
        end else if (ch == CH_BS) begin
          if (crs_col > 0) crs_col--;
        end else begin
          addr               = crs_row * cols + crs_col;
          shadow_cells[addr] = {attr_reg, ch};
          res.cell_written   = 1'b1;
          res.cell_address   = ADDR_W'(addr);
          res.cell_value     = {attr_reg, ch};
          res.display_offset = OFS_W'(crs_row * pitch + crs_col);
          crs_col++;
          if (crs_col >= cols) begin
            crs_col = 0;
            console_newline(cols, rows, redraw);
          end
        end
      end
      REQ_CLEAR: begin
        for (int i = 0; i < STORE_CELLS; i++) shadow_cells[i] = {attr_reg, CH_SPACE};
        crs_row = 0;
        crs_col = 0;
        redraw  = 1'b1;
      end
      REQ_READ: begin
        res.cell_address = idx;
        res.cell_value   = (idx < STORE_CELLS) ? shadow_cells[idx] : '0;
      end
      default: ;
    endcase
    res.cursor_row      = ROW_W'(crs_row);
    res.cursor_col      = COL_W'(crs_col);
    res.cursor_position = ADDR_W'(crs_row * cols + crs_col);
    res.redraw_needed   = redraw;
  endtask

  // drop valid and wait until every report is back
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input int unsigned value);
    drain_results();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = CFG_W'(value);
    do @(posedge clk); while (!cfg_ready);
    case (index)
      REG_LINE_LENGTH: line_len_reg = COL_W'(value);
      REG_ROW_COUNT:   row_cnt_reg  = ROW_W'(value);
      REG_TEXT_ATTR:   attr_reg     = ATTR_W'(value);
      REG_DISP_PITCH:  pitch_reg    = PITCH_W'(value);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // one request transfer, in bursts with random gaps
  task automatic send_request(input logic [1:0] req, input logic [7:0] ch,
                              input logic [ADDR_W-1:0] idx);
    result_t want;
    int      gap;
    @(negedge clk);
    if (!steady_in && burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid      = 1'b1;
    in_req_type   = req;
    in_char_code  = ch;
    in_cell_index = idx;
    do @(posedge clk); while (!in_ready);
    console_apply(req, ch, idx, want);
    awaited_reports.push_back(want);
  endtask

  task automatic put_char(input logic [7:0] ch);
    send_request(REQ_PUT, ch, ADDR_W'($urandom_range(0, 2047)));
  endtask

  task automatic read_cell(input int unsigned idx);
    send_request(REQ_READ, 8'($urandom_range(0, 255)), ADDR_W'(idx));
  endtask

  // reset contents, out-of-range read, unknown request
  task automatic test_power_on();
    read_cell(0);
    read_cell(2047);
    send_request(REQ_NONE, 8'hFF, '1);
  endtask

  // extreme characters and the control characters
  task automatic test_put_controls();
    put_char(8'h00);
    put_char(8'hFF);
    put_char(CH_BS);
    put_char(CH_CR);
    put_char(CH_BS);
    put_char(CH_LF);
  endtask

  // line wrap and scroll in a 3x2 window
  task automatic test_wrap_and_scroll();
    write_reg(REG_LINE_LENGTH, 3);
    write_reg(REG_ROW_COUNT, 2);
    write_reg(REG_TEXT_ATTR, 'hA5);
    write_reg(REG_DISP_PITCH, 1024);
    put_char("x");
    put_char("y");
    put_char("z");
    put_char(CH_LF);
    read_cell(0);
  endtask

  // zero and oversize geometry, zero pitch, cursor clamped after shrinking
  task automatic test_geometry_extremes();
    write_reg(REG_LINE_LENGTH, 0);
    write_reg(REG_ROW_COUNT, 0);
    write_reg(REG_DISP_PITCH, 0);
    put_char("k");
    write_reg(REG_LINE_LENGTH, 127);
    write_reg(REG_ROW_COUNT, 31);
    write_reg(REG_DISP_PITCH, 2047);
    write_reg(REG_TEXT_ATTR, 0);
    put_char("a");
    put_char("b");
    put_char("c");
    write_reg(REG_LINE_LENGTH, 2);
    write_reg(REG_ROW_COUNT, 1);
    put_char("c");
  endtask

  // clear blanks the whole store with the current attribute
  task automatic test_clear();
    write_reg(REG_TEXT_ATTR, 'hFF);
    send_request(REQ_CLEAR, 8'h41, ADDR_W'(5));
    read_cell(STORE_CELLS - 1);
  endtask

  // random traffic over several geometries, mostly puts of random characters and cell reads
  task automatic test_random_traffic();
    int unsigned ll;
    int unsigned rc;
    int unsigned pick;
    int unsigned cells;
    logic [7:0]  ch;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) begin
        ll = MAX_COLUMNS;
        rc = MAX_ROWS;
      end else if (phase == 1) begin
        ll = 127;
        rc = 31;
      end else begin
        ll = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 16);
        rc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
      end
      write_reg(REG_LINE_LENGTH, ll);
      write_reg(REG_ROW_COUNT, rc);
      write_reg(REG_TEXT_ATTR, $urandom_range(0, 255));
      case ($urandom_range(0, 3))
        0:       write_reg(REG_DISP_PITCH, 0);
        1:       write_reg(REG_DISP_PITCH, 2047);
        default: write_reg(REG_DISP_PITCH, $urandom_range(1, 1024));
      endcase
      steady_in  = (phase % 4 == 3);
      steady_out = (phase % 3 == 2);
      cells      = eff_cols() * eff_rows();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 99) == 0) drain_results();
        if (pick < 62) begin
          case ($urandom_range(0, 9))
            0:       ch = CH_LF;
            1:       ch = CH_CR;
            2:       ch = CH_BS;
            default: ch = 8'($urandom_range(0, 255));
          endcase
          put_char(ch);
        end else if (pick < 92) begin
          if ($urandom_range(0, 4) == 0) read_cell($urandom_range(0, 2047));
          else read_cell($urandom_range(0, cells - 1));
        end else if (pick < 94) begin
          send_request(REQ_CLEAR, 8'($urandom_range(0, 255)),
                       ADDR_W'($urandom_range(0, 2047)));
        end else if (pick < 96) begin
          send_request(REQ_NONE, 8'($urandom_range(0, 255)),
                       ADDR_W'($urandom_range(0, 2047)));
        end else begin
          put_char(8'($urandom_range(0, 255)));
        end
      end
    end
    steady_in  = 1'b0;
    steady_out = 1'b0;
  endtask

  // receiver stalls of random length, none started in steady stretches
  always @(negedge clk) begin
    if (rx_stall > 0) begin
      rx_stall--;
      out_ready = 1'b0;
    end else begin
      out_ready = 1'b1;
      if (!steady_out && $urandom_range(0, 5) == 0) rx_stall = $urandom_range(1, 12);
    end
  end

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // compare each result transfer with the oldest awaited report
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_cursor_row, out_cursor_col, out_cursor_position, out_cell_written,
             out_cell_address, out_cell_value, out_display_offset, out_redraw_needed};
      if (awaited_reports.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: unexpected result, cell_value 0x%0h", $time, got.cell_value);
        mismatches++;
      end else begin
        want = awaited_reports.pop_front();
        check_field("cursor_row", 32'(want.cursor_row), 32'(got.cursor_row));
        check_field("cursor_col", 32'(want.cursor_col), 32'(got.cursor_col));
        check_field("cursor_position", 32'(want.cursor_position),
                    32'(got.cursor_position));
        check_field("cell_written", 32'(want.cell_written), 32'(got.cell_written));
        check_field("cell_address", 32'(want.cell_address), 32'(got.cell_address));
        check_field("cell_value", 32'(want.cell_value), 32'(got.cell_value));
        check_field("display_offset", 32'(want.display_offset),
                    32'(got.display_offset));
        check_field("redraw_needed", 32'(want.redraw_needed), 32'(got.redraw_needed));
      end
    end
  end

  // ends the run when no transfer happens for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_LINE_LENGTH;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_req_type   = REQ_PUT;
    in_char_code  = '0;
    in_cell_index = '0;
    console_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_power_on();
    test_put_controls();
    test_wrap_and_scroll();
    test_geometry_extremes();
    test_clear();
    test_random_traffic();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/tcce_pkg.sv
src/tcce_ram.sv
src/tcce_ctrl.sv
src/text_console_cell_engine_unit.sv
src/tcce_checker.sv
sim/testbench.sv
